[src/crd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the byte-wide CRC-32 step for the CRC record deframer.
// Used by every module of the block; depends on nothing.
package crd_pkg;

  localparam int LINE_W   = 13;
  localparam int TLEN_W   = 12;
  localparam int CRC_W    = 32;
  localparam int DIGITS_W = 4;
  localparam int CAP_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int NIB_W    = 4;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 3;

  localparam int MAX_LINE_BYTES = 256;
  localparam int CRC_DIGITS     = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CAP_W-1:0]    CAP_RESET    = 16'd256;
  localparam logic [DIGITS_W-1:0] DIGITS_SAT   = 4'd15;
  localparam logic [CRC_W-1:0]    CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0]    CRC_POLY     = 32'hEDB8_8320;

  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SEP     = 8'h7C;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_A       = 8'h41;
  localparam logic [BYTE_W-1:0] CH_F       = 8'h46;
  localparam logic [BYTE_W-1:0] HEX_TEN    = 8'd10;

  typedef enum logic [1:0] {
    K_DATA,
    K_SEP,
    K_NEWLINE,
    K_EOF
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HEADER   = 3'd1,
    ST_FRAMING  = 3'd2,
    ST_BAD_HEX  = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_TRUNC    = 3'd5,
    ST_TOO_LONG = 3'd6,
    ST_NO_FIT   = 3'd7
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic              sof;
    logic              hex_ok;
    logic [NIB_W-1:0]  nibble;
    logic [BYTE_W-1:0] data;
  } item_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/crd_front.sv]
`timescale 1ns / 1ps
// Front end: classifies each incoming byte transfer into a queue item.
// Depends on crd_pkg.
module crd_front (
  input  logic [crd_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [crd_pkg::IN_USER_W-1:0] in_tuser,
  output crd_pkg::item_t                item
);
  import crd_pkg::*;

  logic [BYTE_W-1:0] b;
  logic              is_digit;
  logic              is_upper;
  logic [BYTE_W-1:0] digit_val;
  logic [BYTE_W-1:0] upper_val;

  assign b         = in_tdata[BYTE_W-1:0];
  assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_upper  = (b >= CH_A) && (b <= CH_F);
  assign digit_val = b - CH_ZERO;
  assign upper_val = b - CH_A + HEX_TEN;

  always_comb begin
    item.data   = b;
    item.sof    = in_tuser[0];
    item.hex_ok = is_digit || is_upper;
    if (is_digit) begin
      item.nibble = digit_val[NIB_W-1:0];
    end else if (is_upper) begin
      item.nibble = upper_val[NIB_W-1:0];
    end else begin
      item.nibble = '0;
    end
    if (in_tuser[1]) begin
      item.kind = K_EOF;
    end else if (b == CH_NEWLINE) begin
      item.kind = K_NEWLINE;
    end else if (b == CH_SEP) begin
      item.kind = K_SEP;
    end else begin
      item.kind = K_DATA;
    end
  end

endmodule

[src/crd_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified items between the front end and the line engine.
// Depends on crd_pkg.
module crd_queue #(
  parameter int DEPTH = crd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  crd_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output crd_pkg::item_t rd_item,
  output logic           empty
);
  import crd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t             slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

[src/crd_back.sv]
`timescale 1ns / 1ps
// Line engine: CRC, separator snapshot, hex gathering, status decision and output register.
// Also holds the destination capacity register. Depends on crd_pkg and crd_report.
module crd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crd_pkg::CAP_W-1:0]      cfg_data,
  input  crd_pkg::item_t                 item,
  input  logic                           item_avail,
  output logic                           item_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [crd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [crd_pkg::OUT_USER_W-1:0] out_tuser
);
  import crd_pkg::*;

  localparam logic [LINE_W-1:0]   MAX_LINE = LINE_W'(MAX_LINE_BYTES);
  localparam logic [DIGITS_W-1:0] DIGITS   = DIGITS_W'(CRC_DIGITS);

  logic [CAP_W-1:0]    cap_r;
  logic [CRC_W-1:0]    crc_r, crc_nxt;
  logic [CRC_W-1:0]    snap_r, snap_nxt;
  logic [LINE_W-1:0]   count_r, count_nxt;
  logic                sep_r, sep_nxt;
  logic [TLEN_W-1:0]   tend_r, tend_nxt;
  logic [DIGITS_W-1:0] digits_r, digits_nxt;
  logic [CRC_W-1:0]    acc_r, acc_nxt;
  logic                bad_r, bad_nxt;
  logic                first_r, first_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             status_r;
  logic [TLEN_W-1:0]   len_r;
  logic [LINE_W-1:0]   span_r;
  logic [CRC_W-1:0]    ocrc_r;

  logic                emit;
  status_t             status;
  logic [LINE_W-1:0]   span;

  logic                rep_sep;
  logic [TLEN_W-1:0]   rep_len;
  logic [CRC_W-1:0]    rep_crc;

  assign cfg_ready  = 1'b1;
  assign item_pop   = item_avail && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{(OUT_DATA_W-TLEN_W-LINE_W-CRC_W){1'b0}}, ocrc_r, span_r, len_r};

  assign rep_sep = (item.sof && (item.kind != K_EOF)) ? 1'b0 : sep_r;

  crd_report u_report (
    .sep  (rep_sep),
    .tend (tend_r),
    .snap (snap_r),
    .len  (rep_len),
    .crc  (rep_crc)
  );

  always_comb begin
    logic              sof_eff;
    logic [CRC_W-1:0]  c_crc;
    logic [CRC_W-1:0]  c_snap;
    logic [LINE_W-1:0] c_count;
    logic              c_sep;
    logic [TLEN_W-1:0] c_tend;
    logic [DIGITS_W-1:0] c_digits;
    logic [CRC_W-1:0]  c_acc;
    logic              c_bad;
    logic              c_first;
    logic              clear;
    logic [LINE_W-1:0] next_count;

    sof_eff  = item.sof && (item.kind != K_EOF);
    c_crc    = sof_eff ? CRC_INIT : crc_r;
    c_snap   = sof_eff ? '0 : snap_r;
    c_count  = sof_eff ? '0 : count_r;
    c_sep    = sof_eff ? 1'b0 : sep_r;
    c_tend   = sof_eff ? '0 : tend_r;
    c_digits = sof_eff ? '0 : digits_r;
    c_acc    = sof_eff ? '0 : acc_r;
    c_bad    = sof_eff ? 1'b0 : bad_r;
    c_first  = sof_eff ? 1'b1 : first_r;
    next_count = c_count + 1'b1;

    emit   = 1'b0;
    status = ST_OK;
    span   = next_count;
    clear  = 1'b0;

    crc_nxt    = c_crc;
    snap_nxt   = c_snap;
    count_nxt  = c_count;
    sep_nxt    = c_sep;
    tend_nxt   = c_tend;
    digits_nxt = c_digits;
    acc_nxt    = c_acc;
    bad_nxt    = c_bad;
    first_nxt  = c_first;

    unique case (item.kind)
      K_EOF: begin
        emit   = (c_count != '0);
        status = ST_TRUNC;
        span   = c_count;
        clear  = 1'b1;
      end
      K_NEWLINE: begin
        emit  = 1'b1;
        clear = 1'b1;
        priority if (c_first && !c_sep) begin
          status = ST_HEADER;
        end else if (!c_sep || c_digits != DIGITS) begin
          status = ST_FRAMING;
        end else if (c_bad) begin
          status = ST_BAD_HEX;
        end else if (c_acc != ~c_snap) begin
          status = ST_MISMATCH;
        end else if ({{(CAP_W-TLEN_W){1'b0}}, c_tend} >= cap_r) begin
          status = ST_NO_FIT;
          span   = '0;
        end else begin
          status = ST_OK;
        end
      end
      K_SEP, K_DATA: begin
        if (next_count >= MAX_LINE) begin
          emit   = 1'b1;
          status = ST_TOO_LONG;
          span   = MAX_LINE;
          clear  = 1'b1;
        end else begin
          if (item.kind == K_SEP) begin
            snap_nxt   = c_crc;
            tend_nxt   = c_count[TLEN_W-1:0];
            sep_nxt    = 1'b1;
            digits_nxt = '0;
            acc_nxt    = '0;
            bad_nxt    = 1'b0;
          end else if (c_sep) begin
            if (c_digits < DIGITS) begin
              acc_nxt = {c_acc[CRC_W-NIB_W-1:0], item.nibble};
              if (!item.hex_ok) begin
                bad_nxt = 1'b1;
              end
            end
            if (c_digits < DIGITS_SAT) begin
              digits_nxt = c_digits + 1'b1;
            end
          end
          crc_nxt   = crc_byte(c_crc, item.data);
          count_nxt = next_count;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    if (clear) begin
      crc_nxt    = CRC_INIT;
      snap_nxt   = '0;
      count_nxt  = '0;
      sep_nxt    = 1'b0;
      tend_nxt   = '0;
      digits_nxt = '0;
      acc_nxt    = '0;
      bad_nxt    = 1'b0;
      first_nxt  = 1'b0;
    end

    if (item_pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      crc_r       <= CRC_INIT;
      snap_r      <= '0;
      count_r     <= '0;
      sep_r       <= 1'b0;
      tend_r      <= '0;
      digits_r    <= '0;
      acc_r       <= '0;
      bad_r       <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (item_pop) begin
        crc_r    <= crc_nxt;
        snap_r   <= snap_nxt;
        count_r  <= count_nxt;
        sep_r    <= sep_nxt;
        tend_r   <= tend_nxt;
        digits_r <= digits_nxt;
        acc_r    <= acc_nxt;
        bad_r    <= bad_nxt;
        first_r  <= first_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && emit) begin
      status_r <= status;
      len_r    <= rep_len;
      span_r   <= span;
      ocrc_r   <= rep_crc;
    end
  end

endmodule

[src/crd_top_unused_placeholder_never.sv]
`timescale 1ns / 1ps
// Output field select for the CRC record deframer line reports.
// Depends on crd_pkg.
module crd_report (
  input  logic                      sep,
  input  logic [crd_pkg::TLEN_W-1:0] tend,
  input  logic [crd_pkg::CRC_W-1:0]  snap,
  output logic [crd_pkg::TLEN_W-1:0] len,
  output logic [crd_pkg::CRC_W-1:0]  crc
);
  import crd_pkg::*;

  assign len = sep ? tend : '0;
  assign crc = sep ? ~snap : '0;

endmodule

[src/crc_record_deframer.sv]
`timescale 1ns / 1ps
// Checks log lines of text, '|', eight hex CRC digits and newline; one report per line.
// Path: a byte transfer is held in the queue, and its report is registered in the line engine.
// Throughput: one byte per cycle while the output is not stalled, set by the byte-wide CRC-32 step.
// Reset: synchronous on rst_n low; line state clears and capacity returns to 256.
// Depends on crd_pkg, crd_front, crd_queue and crd_back.
module crc_record_deframer #(
  parameter int QUEUE_DEPTH = crd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [crd_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] byte_value
  input  logic [crd_pkg::IN_USER_W-1:0]  in_tuser,   // [0] at_file_start, [1] end_of_file
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [crd_pkg::OUT_DATA_W-1:0] out_tdata,  // [11:0] text_length, [24:12] line_span,
                                                     // [56:25] computed_crc
  output logic [crd_pkg::OUT_USER_W-1:0] out_tuser,  // [2:0] line_status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crd_pkg::CAP_W-1:0]      cfg_data    // dest_capacity
);
  import crd_pkg::*;

  item_t front_item;
  item_t back_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  assign in_tready = !q_full;

  crd_front u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .item     (front_item)
  );

  crd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_tvalid),
    .wr_item (front_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (back_item),
    .empty   (q_empty)
  );

  crd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .item       (back_item),
    .item_avail (!q_empty),
    .item_pop   (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
